### src/ppc_pkg.sv
// Shared constants and types for the polygon point containment block.
// Self-contained; imported by polygon_point_containment.

package ppc_pkg;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_COORD_BITS   = 16;

    // A polygon needs at least this many vertices to enclose anything
    localparam int MIN_POLY = 3;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEST   = 2'd2,
        OP_BOX    = 2'd3
    } op_t;

endpackage

### src/polygon_point_containment.sv
// Polygon vertex store with crossing-number point test and bounding box query.
// Depends on ppc_pkg for default sizes, the minimum polygon size and operation codes.
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------------------
//  command   start, busy          operation, coord_x, coord_y
//  result    done (one cycle)     inside_res, box_empty, box_x, box_y, box_w,
//                                 box_h, vertex_total, status
//
// Clear, append, a short test and an empty box query never enter the walk; busy stays low.
// A point test or box query walks the vertex memory, one read per cycle over
// vertex_total + 1 addresses, then drains through the difference, multiply and
// compare stages.
// busy is high during the walk. rst_n clears the vertex count; the store is not cleared.
// done cannot be held off by the receiver; results are taken in the cycle they show.

module polygon_point_containment
    import ppc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_BITS   = DEF_COORD_BITS,
    localparam int CNT_W       = $clog2(MAX_VERTICES + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   operation,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    output logic                         done,
    output logic                         inside_res,
    output logic                         box_empty,
    output logic signed [COORD_BITS-1:0] box_x,
    output logic signed [COORD_BITS-1:0] box_y,
    output logic [COORD_BITS-1:0]        box_w,
    output logic [COORD_BITS-1:0]        box_h,
    output logic [CNT_W-1:0]             vertex_total,
    output logic                         status
);

    localparam int AW     = $clog2(MAX_VERTICES);
    localparam int STEP_W = $clog2(MAX_VERTICES + 2);
    localparam int DW     = COORD_BITS + 1;
    localparam int PW     = 2 * DW;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    mode_box_reg;
    logic                    s1_valid_reg;
    logic                    s1_first_reg;
    logic                    s2_valid_reg;
    logic                    s3_valid_reg;
    logic                    done_reg;
    logic                    inside_reg;
    logic                    empty_reg;
    logic signed [COORD_BITS-1:0] box_x_reg;
    logic signed [COORD_BITS-1:0] box_y_reg;
    logic [COORD_BITS-1:0]   box_w_reg;
    logic [COORD_BITS-1:0]   box_h_reg;
    logic [CNT_W-1:0]        total_reg;
    logic                    status_reg;

    // vertex memories
    logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] rd_x_reg;
    logic signed [COORD_BITS-1:0] rd_y_reg;

    // datapath
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic signed [COORD_BITS-1:0] min_x_reg;
    logic signed [COORD_BITS-1:0] max_x_reg;
    logic signed [COORD_BITS-1:0] min_y_reg;
    logic signed [COORD_BITS-1:0] max_y_reg;
    logic signed [DW-1:0]    dx_reg;
    logic signed [DW-1:0]    dy_reg;
    logic signed [DW-1:0]    lx_reg;
    logic signed [DW-1:0]    ly_reg;
    logic                    s2_cross_reg;
    logic                    s2_dypos_reg;
    logic signed [PW-1:0]    pa_reg;
    logic signed [PW-1:0]    pb_reg;
    logic                    s3_cross_reg;
    logic                    s3_dypos_reg;
    logic                    inside_acc_reg;
    logic                    inside_next;

    logic                    accept;
    logic                    full;
    logic                    wr_en;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [CNT_W-1:0]        cnt_m1;
    logic [STEP_W-1:0]       step_m1;
    logic                    walk_end;
    logic signed [PW-1:0]    pa_next;
    logic signed [PW-1:0]    pb_next;
    logic                    hit;
    op_t                     op;

    assign op       = op_t'(operation);
    assign busy     = (state_reg == ST_WALK);
    assign accept   = start && !busy;
    assign full     = (count_reg == CNT_W'(MAX_VERTICES));
    assign wr_en    = accept && (op == OP_APPEND) && !full;

    // first read fetches the closing vertex, then vertices in order
    assign cnt_m1   = count_reg - 1'b1;
    assign step_m1  = step_reg - 1'b1;
    assign rd_addr  = (step_reg == '0) ? cnt_m1[AW-1:0] : step_m1[AW-1:0];
    assign rd_en    = busy && (step_reg <= STEP_W'(count_reg));
    assign walk_end = busy && (step_reg > STEP_W'(count_reg))
                      && !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;

    assign pa_next  = lx_reg * dy_reg;
    assign pb_next  = dx_reg * ly_reg;
    assign hit      = s3_dypos_reg ? (pa_reg < pb_reg) : (pb_reg < pa_reg);
    assign inside_next = inside_acc_reg ^ (s3_valid_reg && s3_cross_reg && hit);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[count_reg[AW-1:0]] <= coord_x;
            mem_y[count_reg[AW-1:0]] <= coord_y;
        end
        if (rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
        end
    end

    // edge pipeline and box accumulators
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg         <= coord_x;
            py_reg         <= coord_y;
            inside_acc_reg <= 1'b0;
        end
        else
        begin
            inside_acc_reg <= inside_next;
        end

        if (s1_valid_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
            if (s1_first_reg)
            begin
                min_x_reg <= rd_x_reg;
                max_x_reg <= rd_x_reg;
                min_y_reg <= rd_y_reg;
                max_y_reg <= rd_y_reg;
            end
            else
            begin
                if (rd_x_reg < min_x_reg) min_x_reg <= rd_x_reg;
                if (rd_x_reg > max_x_reg) max_x_reg <= rd_x_reg;
                if (rd_y_reg < min_y_reg) min_y_reg <= rd_y_reg;
                if (rd_y_reg > max_y_reg) max_y_reg <= rd_y_reg;
            end
            // current vertex is i, previous is j
            dx_reg       <= DW'(prev_x_reg) - DW'(rd_x_reg);
            dy_reg       <= DW'(prev_y_reg) - DW'(rd_y_reg);
            lx_reg       <= DW'(px_reg) - DW'(rd_x_reg);
            ly_reg       <= DW'(py_reg) - DW'(rd_y_reg);
            s2_cross_reg <= (rd_y_reg > py_reg) != (prev_y_reg > py_reg);
            s2_dypos_reg <= prev_y_reg > rd_y_reg;
        end

        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        s3_cross_reg <= s2_cross_reg;
        s3_dypos_reg <= s2_dypos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            step_reg     <= '0;
            mode_box_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            inside_reg   <= 1'b0;
            empty_reg    <= 1'b0;
            box_x_reg    <= '0;
            box_y_reg    <= '0;
            box_w_reg    <= '0;
            box_h_reg    <= '0;
            total_reg    <= '0;
            status_reg   <= 1'b0;
        end
        else
        begin
            done_reg     <= 1'b0;
            s1_valid_reg <= rd_en;
            s1_first_reg <= rd_en && (step_reg == '0);
            s2_valid_reg <= s1_valid_reg && !s1_first_reg && !mode_box_reg;
            s3_valid_reg <= s2_valid_reg;
            if (rd_en)
                step_reg <= step_reg + 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        inside_reg <= 1'b0;
                        empty_reg  <= 1'b0;
                        box_x_reg  <= '0;
                        box_y_reg  <= '0;
                        box_w_reg  <= '0;
                        box_h_reg  <= '0;
                        status_reg <= 1'b0;
                        total_reg  <= count_reg;
                        step_reg   <= '0;
                        unique case (op)
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                                total_reg <= '0;
                                done_reg  <= 1'b1;
                            end
                            OP_APPEND:
                            begin
                                if (full)
                                begin
                                    status_reg <= 1'b1;
                                end
                                else
                                begin
                                    count_reg <= count_reg + 1'b1;
                                    total_reg <= count_reg + 1'b1;
                                end
                                done_reg <= 1'b1;
                            end
                            OP_TEST:
                            begin
                                mode_box_reg <= 1'b0;
                                if (count_reg < CNT_W'(MIN_POLY))
                                    done_reg <= 1'b1;
                                else
                                    state_reg <= ST_WALK;
                            end
                            OP_BOX:
                            begin
                                mode_box_reg <= 1'b1;
                                if (count_reg == '0)
                                begin
                                    empty_reg <= 1'b1;
                                    done_reg  <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_WALK;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_WALK:
                begin
                    if (walk_end)
                    begin
                        if (mode_box_reg)
                        begin
                            box_x_reg <= min_x_reg;
                            box_y_reg <= min_y_reg;
                            box_w_reg <= COORD_BITS'(max_x_reg - min_x_reg);
                            box_h_reg <= COORD_BITS'(max_y_reg - min_y_reg);
                        end
                        else
                        begin
                            inside_reg <= inside_acc_reg;
                        end
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign inside_res   = inside_reg;
    assign box_empty    = empty_reg;
    assign box_x        = box_x_reg;
    assign box_y        = box_y_reg;
    assign box_w        = box_w_reg;
    assign box_h        = box_h_reg;
    assign vertex_total = total_reg;
    assign status       = status_reg;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for polygon_point_containment: directed table, then random polygons.
// Depends on ppc_pkg and the block under test; expected results come from a local predictor or the typed rows.

module tb;
    import ppc_pkg::*;

    localparam int MAX_VERTS   = DEF_MAX_VERTICES;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_TICKS = 40;

    typedef struct packed {
        logic        in_poly;
        logic        empty;
        logic [15:0] bx;
        logic [15:0] by;
        logic [15:0] bw;
        logic [15:0] bh;
        logic [4:0]  total;
        logic        stat;
    } poly_result_t;

    typedef struct packed {
        op_t          op;
        logic [15:0]  x;
        logic [15:0]  y;
        logic         typed;
        poly_result_t want;
    } poly_cmd_t;

    typedef struct {
        poly_cmd_t cmd;
        int        reps;
    } poly_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         operation = OP_CLEAR;
    logic signed [15:0] coord_x = '0;
    logic signed [15:0] coord_y = '0;
    logic               busy;
    logic               done;
    logic               inside_res;
    logic               box_empty;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [15:0]        box_w;
    logic [15:0]        box_h;
    logic [4:0]         vertex_total;
    logic               status;

    // Shadow copy of the vertex list
    logic signed [15:0] shadow_vx [0:MAX_VERTS-1];
    logic signed [15:0] shadow_vy [0:MAX_VERTS-1];
    int                 shadow_count = 0;

    poly_cmd_t    queued_cmds [$];
    poly_result_t expected_results [$];
    poly_row_t    directed_rows [$];
    poly_cmd_t    accepted_cmd;
    poly_result_t predicted;
    poly_result_t observed;
    int           failures = 0;
    int           commands_issued = 0;
    int           sender_idle_pct = 0;

    polygon_point_containment uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .done         (done),
        .inside_res   (inside_res),
        .box_empty    (box_empty),
        .box_x        (box_x),
        .box_y        (box_y),
        .box_w        (box_w),
        .box_h        (box_h),
        .vertex_total (vertex_total),
        .status       (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Crossing-number parity with exact cross-multiplied edge comparison
    function automatic logic point_inside(logic signed [15:0] px, logic signed [15:0] py);
        logic   parity;
        logic   hit;
        int     i;
        int     j;
        longint xi, yi, xj, yj, dx, dy, lx, ly;
        parity = 1'b0;
        if (shadow_count < MIN_POLY)
            return 1'b0;
        j = shadow_count - 1;
        for (i = 0; i < shadow_count; i++)
        begin
            xi = shadow_vx[i];
            yi = shadow_vy[i];
            xj = shadow_vx[j];
            yj = shadow_vy[j];
            if ((yi > py) != (yj > py))
            begin
                dy = yj - yi;
                dx = xj - xi;
                lx = px - xi;
                ly = py - yi;
                hit = (dy > 0) ? (lx * dy < dx * ly) : (dx * ly < lx * dy);
                if (hit)
                    parity = ~parity;
            end
            j = i;
        end
        return parity;
    endfunction

    function automatic poly_result_t step_polygon(op_t op, logic signed [15:0] x,
                                                  logic signed [15:0] y);
        poly_result_t       r;
        logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
        int                 k;
        r = '0;
        case (op)
            OP_CLEAR:
                shadow_count = 0;
            OP_APPEND:
                if (shadow_count < MAX_VERTS)
                begin
                    shadow_vx[shadow_count] = x;
                    shadow_vy[shadow_count] = y;
                    shadow_count++;
                end
                else
                    r.stat = 1'b1;
            OP_TEST:
                r.in_poly = point_inside(x, y);
            default:
                if (shadow_count == 0)
                    r.empty = 1'b1;
                else
                begin
                    lo_x = shadow_vx[0];
                    hi_x = lo_x;
                    lo_y = shadow_vy[0];
                    hi_y = lo_y;
                    for (k = 1; k < shadow_count; k++)
                    begin
                        if (shadow_vx[k] < lo_x) lo_x = shadow_vx[k];
                        if (shadow_vx[k] > hi_x) hi_x = shadow_vx[k];
                        if (shadow_vy[k] < lo_y) lo_y = shadow_vy[k];
                        if (shadow_vy[k] > hi_y) hi_y = shadow_vy[k];
                    end
                    r.bx = lo_x;
                    r.by = lo_y;
                    r.bw = hi_x - lo_x;
                    r.bh = hi_y - lo_y;
                end
        endcase
        r.total = shadow_count[4:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            failures++;
        end
    endtask

    // Predict on acceptance and check on done in one process, so order within a step is moot
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            accepted_cmd = queued_cmds.pop_front();
            predicted = step_polygon(accepted_cmd.op, accepted_cmd.x, accepted_cmd.y);
            expected_results.push_back(accepted_cmd.typed ? accepted_cmd.want : predicted);
        end
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                failures++;
            end
            else
            begin
                observed = expected_results.pop_front();
                check_field("inside_res", 16'(observed.in_poly), 16'(inside_res));
                check_field("box_empty", 16'(observed.empty), 16'(box_empty));
                check_field("box_x", observed.bx, box_x);
                check_field("box_y", observed.by, box_y);
                check_field("box_w", observed.bw, box_w);
                check_field("box_h", observed.bh, box_h);
                check_field("vertex_total", 16'(observed.total), 16'(vertex_total));
                check_field("status", 16'(observed.stat), 16'(status));
            end
        end
    end

    // Drive one command and hold it until the block takes it
    task automatic issue(op_t op, logic [15:0] x, logic [15:0] y, logic typed,
                         poly_result_t want);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        queued_cmds.push_back({op, x, y, typed, want});
        start     <= 1'b1;
        operation <= op;
        coord_x   <= x;
        coord_y   <= y;
        do
            @(posedge clk);
        while (busy);
        commands_issued++;
    endtask

    task automatic add_row(op_t op, logic [15:0] x, logic [15:0] y, int reps, logic typed,
                           poly_result_t want);
        poly_row_t row;
        row.cmd  = {op, x, y, typed, want};
        row.reps = reps;
        directed_rows.push_back(row);
    endtask

    function automatic logic [15:0] jitter(logic signed [15:0] centre, int span);
        return 16'(int'(centre) + int'($urandom_range(2 * span)) - span);
    endfunction

    // Usually clear, then build a random polygon, probe it, then ask for its box
    task automatic run_session();
        int                 nverts, ntests, span, pick, k, r;
        logic signed [15:0] cx, cy;
        logic [15:0]        px, py;
        logic signed [15:0] vx [0:17];
        logic signed [15:0] vy [0:17];
        if ($urandom_range(4) != 0)
            issue(OP_CLEAR, 16'($urandom), 16'($urandom), 1'b0, '0);
        r = $urandom_range(99);
        if (r < 10)
            nverts = $urandom_range(2);
        else if (r < 85)
            nverts = $urandom_range(3, 8);
        else
            nverts = $urandom_range(9, 18);
        span = 1 << $urandom_range(2, 15);
        cx = 16'($urandom);
        cy = 16'($urandom);
        for (k = 0; k < nverts; k++)
        begin
            vx[k] = jitter(cx, span);
            vy[k] = jitter(cy, span);
            issue(OP_APPEND, vx[k], vy[k], 1'b0, '0);
        end
        ntests = $urandom_range(2, 8);
        for (k = 0; k < ntests; k++)
        begin
            r = $urandom_range(5);
            pick = (nverts > 0) ? $urandom_range(nverts - 1) : 0;
            if (r == 0 && nverts > 0)
            begin
                px = vx[pick];
                py = vy[pick];
            end
            else if (r == 1 && nverts > 0)
            begin
                // share a vertex's y to hit the strict straddle comparison
                px = jitter(cx, span);
                py = vy[pick];
            end
            else
            begin
                px = jitter(cx, span + span / 4);
                py = jitter(cy, span + span / 4);
            end
            issue(OP_TEST, px, py, 1'b0, '0);
        end
        issue(OP_BOX, 16'($urandom), 16'($urandom), 1'b0, '0);
    endtask

    task automatic run_phase(int idle_pct, int quota);
        int phase_end;
        sender_idle_pct = idle_pct;
        phase_end = commands_issued + quota;
        while (commands_issued < phase_end)
        begin
            if ($urandom_range(9) == 0)
                issue(op_t'($urandom_range(3)), 16'($urandom), 16'($urandom), 1'b0, '0);
            else
                run_session();
        end
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** polygon_point_containment: FAILED **");
        $finish;
    end

    initial
    begin
        int n, k;
        // empty store, too-few-vertex test, then the four extreme corners
        add_row(OP_BOX, 16'h0000, 16'h0000, 1, 1'b1,
                {1'b0, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 5'd0, 1'b0});
        add_row(OP_TEST, 16'h0000, 16'h0000, 1, 1'b1, '0);
        add_row(OP_APPEND, 16'h8000, 16'h8000, 1, 1'b1,
                {1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 5'd1, 1'b0});
        add_row(OP_APPEND, 16'h7fff, 16'h8000, 1, 1'b1,
                {1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 5'd2, 1'b0});
        add_row(OP_TEST, 16'h0000, 16'h8000, 1, 1'b1,
                {1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 5'd2, 1'b0});
        add_row(OP_APPEND, 16'h7fff, 16'h7fff, 1, 1'b1,
                {1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 5'd3, 1'b0});
        add_row(OP_APPEND, 16'h8000, 16'h7fff, 1, 1'b1,
                {1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 5'd4, 1'b0});
        add_row(OP_BOX, 16'hffff, 16'hffff, 1, 1'b1,
                {1'b0, 1'b0, 16'h8000, 16'h8000, 16'hffff, 16'hffff, 5'd4, 1'b0});
        // centre, edges and corners of the full-range square
        add_row(OP_TEST, 16'h0000, 16'h0000, 1, 1'b0, '0);
        add_row(OP_TEST, 16'h8000, 16'h0000, 1, 1'b0, '0);
        add_row(OP_TEST, 16'h7fff, 16'h0000, 1, 1'b0, '0);
        add_row(OP_TEST, 16'h7fff, 16'h7fff, 1, 1'b0, '0);
        add_row(OP_TEST, 16'h0000, 16'h8000, 1, 1'b0, '0);
        add_row(OP_TEST, 16'h0000, 16'h7fff, 1, 1'b0, '0);
        add_row(OP_TEST, 16'h8000, 16'h8000, 1, 1'b0, '0);
        // fill the store, then overflow it
        add_row(OP_APPEND, 16'h0064, 16'hffce, 12, 1'b0, '0);
        add_row(OP_APPEND, 16'h0005, 16'h0005, 1, 1'b1,
                {1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 5'd16, 1'b1});
        add_row(OP_TEST, 16'h0010, 16'h0010, 1, 1'b0, '0);
        add_row(OP_BOX, 16'h0000, 16'h0000, 1, 1'b0, '0);
        add_row(OP_CLEAR, 16'h7fff, 16'hffff, 1, 1'b1, '0);
        add_row(OP_BOX, 16'h5555, 16'haaaa, 1, 1'b1,
                {1'b0, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 5'd0, 1'b0});
        // triangle with edges of both dy signs
        add_row(OP_APPEND, 16'h0000, 16'h0000, 1, 1'b0, '0);
        add_row(OP_APPEND, 16'h00a0, 16'h0000, 1, 1'b0, '0);
        add_row(OP_APPEND, 16'h0050, 16'hff60, 1, 1'b0, '0);
        add_row(OP_TEST, 16'h0050, 16'hfff0, 1, 1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 12;
        for (n = 0; n < directed_rows.size(); n++)
            for (k = 0; k < directed_rows[n].reps; k++)
                issue(directed_rows[n].cmd.op, directed_rows[n].cmd.x, directed_rows[n].cmd.y,
                      directed_rows[n].cmd.typed, directed_rows[n].cmd.want);

        run_phase(12, 700);
        run_phase(69, 700);
        run_phase(0, 560);

        start <= 1'b0;
        while (expected_results.size() != 0 || queued_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            failures++;
        end
        if (failures == 0)
            $display("** polygon_point_containment: PASSED **");
        else
            $display("** polygon_point_containment: FAILED **");
        $finish;
    end

endmodule
